[rtl/core/sqd_pkg.sv]
// ----------------------------------------------------------------------------
// sqd_pkg
// Shared types and constants for the square-with-diagonals pixel shader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sqd_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int THICK_W        = 8;
    localparam int HALF_W         = THICK_W - 1;
    localparam int SQ_W           = 2 * HALF_W;
    localparam int COLOR_W        = 24;
    localparam int FILL_W         = COLOR_W + 1;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;

    localparam logic [THICK_W-1:0] THICK_RESET = THICK_W'(1);

    typedef enum logic [2:0] {
        REG_X_ORIGIN       = 3'd0,
        REG_Y_ORIGIN       = 3'd1,
        REG_SIDE_LENGTH    = 3'd2,
        REG_LINE_THICKNESS = 3'd3,
        REG_LINE_COLOR     = 3'd4,
        REG_FILL_SETTING   = 3'd5,
        REG_IMAGE_HEIGHT   = 3'd6,
        REG_IMAGE_WIDTH    = 3'd7
    } reg_idx_t;

    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [HALF_W-1:0]  mag_t;
    typedef logic [SQ_W-1:0]    sq_t;

    // per-item coverage flags
    typedef struct packed {
        logic       edge_hit;
        logic       fill_hit;
        logic       diag_hit;
        logic       lim_ok;
        logic [1:0] ok_dx;
        logic [1:0] ok_dy;
    } hit_t;

endpackage

`default_nettype wire

[rtl/core/sqd_cfg.sv]
// ----------------------------------------------------------------------------
// sqd_cfg
// APB register file holding the shape, color and image size settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqd_cfg
    import sqd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic      [APB_DATA_W-1:0]   prdata,
    output logic      [COORD_BITS-1:0]   x_origin,
    output logic      [COORD_BITS-1:0]   y_origin,
    output logic      [COORD_BITS-1:0]   side_length,
    output logic      [THICK_W-1:0]      line_thickness,
    output color_t                       line_color,
    output logic      [FILL_W-1:0]       fill_setting,
    output logic      [COORD_BITS:0]     image_height,
    output logic      [COORD_BITS:0]     image_width
);

    logic [COORD_BITS-1:0] x_origin_reg;
    logic [COORD_BITS-1:0] y_origin_reg;
    logic [COORD_BITS-1:0] side_length_reg;
    logic [THICK_W-1:0]    line_thickness_reg;
    color_t                line_color_reg;
    logic [FILL_W-1:0]     fill_setting_reg;
    logic [COORD_BITS:0]   image_height_reg;
    logic [COORD_BITS:0]   image_width_reg;
    reg_idx_t              idx;
    logic                  wr_en;

    assign idx   = reg_idx_t'(paddr[4:2]);
    assign wr_en = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_origin_reg       <= '0;
            y_origin_reg       <= '0;
            side_length_reg    <= '0;
            line_thickness_reg <= THICK_RESET;
            line_color_reg     <= '0;
            fill_setting_reg   <= '0;
            image_height_reg   <= (COORD_BITS+1)'(1);
            image_width_reg    <= (COORD_BITS+1)'(1);
        end else if (wr_en) begin
            unique case (idx)
                REG_X_ORIGIN:       x_origin_reg       <= pwdata[COORD_BITS-1:0];
                REG_Y_ORIGIN:       y_origin_reg       <= pwdata[COORD_BITS-1:0];
                REG_SIDE_LENGTH:    side_length_reg    <= pwdata[COORD_BITS-1:0];
                REG_LINE_THICKNESS: line_thickness_reg <= pwdata[THICK_W-1:0];
                REG_LINE_COLOR:     line_color_reg     <= pwdata[COLOR_W-1:0];
                REG_FILL_SETTING:   fill_setting_reg   <= pwdata[FILL_W-1:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= pwdata[COORD_BITS:0];
                REG_IMAGE_WIDTH:    image_width_reg    <= pwdata[COORD_BITS:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_X_ORIGIN:       prdata = APB_DATA_W'(x_origin_reg);
            REG_Y_ORIGIN:       prdata = APB_DATA_W'(y_origin_reg);
            REG_SIDE_LENGTH:    prdata = APB_DATA_W'(side_length_reg);
            REG_LINE_THICKNESS: prdata = APB_DATA_W'(line_thickness_reg);
            REG_LINE_COLOR:     prdata = APB_DATA_W'(line_color_reg);
            REG_FILL_SETTING:   prdata = APB_DATA_W'(fill_setting_reg);
            REG_IMAGE_HEIGHT:   prdata = APB_DATA_W'(image_height_reg);
            REG_IMAGE_WIDTH:    prdata = APB_DATA_W'(image_width_reg);
        endcase
    end

    assign x_origin       = x_origin_reg;
    assign y_origin       = y_origin_reg;
    assign side_length    = side_length_reg;
    assign line_thickness = line_thickness_reg;
    assign line_color     = line_color_reg;
    assign fill_setting   = fill_setting_reg;
    assign image_height   = image_height_reg;
    assign image_width    = image_width_reg;

endmodule

`default_nettype wire

[rtl/core/sqd_diff.sv]
// ----------------------------------------------------------------------------
// sqd_diff
// Stage 1: pixel position relative to the square origin, image bounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqd_diff
    import sqd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SW         = COORD_BITS + 5
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [COORD_BITS-1:0]  pixel_row,
    input  wire logic [COORD_BITS-1:0]  pixel_col,
    input  wire color_t                 in_color,
    input  wire logic [COORD_BITS-1:0]  x_origin,
    input  wire logic [COORD_BITS-1:0]  y_origin,
    input  wire logic [COORD_BITS:0]    image_height,
    input  wire logic [COORD_BITS:0]    image_width,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [SW-1:0]        cx,
    output logic signed [SW-1:0]        cy,
    output logic                        in_image,
    output logic                        lim_ok,
    output color_t                      out_color
);

    logic                valid_reg;
    logic signed [SW-1:0] cx_reg, cx_next;
    logic signed [SW-1:0] cy_reg, cy_next;
    logic                in_image_reg, in_image_next;
    logic                lim_ok_reg, lim_ok_next;
    color_t              color_reg;
    logic                row_lt_w, col_lt_h;

    // cx = c - X, cy = (H - r) - Y
    always_comb begin
        cx_next = $signed({{(SW-COORD_BITS){1'b0}}, pixel_col})
                - $signed({{(SW-COORD_BITS){1'b0}}, x_origin});
        cy_next = $signed({{(SW-COORD_BITS-1){1'b0}}, image_height})
                - $signed({{(SW-COORD_BITS){1'b0}}, pixel_row})
                - $signed({{(SW-COORD_BITS){1'b0}}, y_origin});
        in_image_next = ({1'b0, pixel_row} < image_height) &&
                        ({1'b0, pixel_col} < image_width);
        row_lt_w    = {1'b0, pixel_row} < image_width;
        col_lt_h    = {1'b0, pixel_col} < image_height;
        lim_ok_next = in_image_next && row_lt_w && col_lt_h;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            cx_reg       <= cx_next;
            cy_reg       <= cy_next;
            in_image_reg <= in_image_next;
            lim_ok_reg   <= lim_ok_next;
            color_reg    <= in_color;
        end
    end

    assign out_valid = valid_reg;
    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign in_image  = in_image_reg;
    assign lim_ok    = lim_ok_reg;
    assign out_color = color_reg;

endmodule

`default_nettype wire

[rtl/core/sqd_test.sv]
// ----------------------------------------------------------------------------
// sqd_test
// Stage 2: outline, fill and diagonal band tests; corner disc offsets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqd_test
    import sqd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SW         = COORD_BITS + 5
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic signed [SW-1:0]   cx,
    input  wire logic signed [SW-1:0]   cy,
    input  wire logic                   in_image,
    input  wire logic                   lim_ok,
    input  wire color_t                 in_color,
    input  wire logic [COORD_BITS-1:0]  side_length,
    input  wire logic [THICK_W-1:0]     line_thickness,
    input  wire logic                   fill_en,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output hit_t                        hits,
    output mag_t                        dx0,
    output mag_t                        dx1,
    output mag_t                        dy0,
    output mag_t                        dy1,
    output color_t                      out_color
);

    logic  valid_reg;
    hit_t  hits_reg, hits_next;
    mag_t  dx0_reg, dx1_reg, dy0_reg, dy1_reg;
    mag_t  dx0_next, dx1_next, dy0_next, dy1_next;
    color_t color_reg;

    logic signed [SW-1:0] s, h, nh, q, tm1, cxs, cys, smh, smq, d1, d2;
    logic                 hband, vband, fill_col, fill_row, diag_col;

    function automatic logic in_rng(input logic signed [SW-1:0] v,
                                    input logic signed [SW-1:0] lo,
                                    input logic signed [SW-1:0] hi);
        in_rng = (v >= lo) && (v <= hi);
    endfunction

    function automatic mag_t mag_of(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] n;
        n      = -v;
        mag_of = v[SW-1] ? n[HALF_W-1:0] : v[HALF_W-1:0];
    endfunction

    always_comb begin
        s   = $signed({{(SW-COORD_BITS){1'b0}}, side_length});
        h   = $signed({{(SW-HALF_W){1'b0}}, line_thickness[THICK_W-1:1]});
        q   = $signed({{(SW-HALF_W+1){1'b0}}, line_thickness[THICK_W-1:2]});
        tm1 = $signed({{(SW-THICK_W){1'b0}}, line_thickness}) - SW'(1);
        nh  = -h;
        cxs = cx - s;
        cys = cy - s;
        smh = s - h;
        smq = s - q;
        d1  = cx - cy + h - q;
        d2  = q + s - cx - cy;

        hband = (cx >= 0) && (cx < s) && (in_rng(cy, nh, h) || in_rng(cys, nh, h));
        vband = (cy >= 0) && (cy < s) && (in_rng(cx, nh, h) || in_rng(cxs, nh, h));

        fill_col = (cx >= h) && (cx < smh);
        fill_row = (cy >= h) && (cy < smh);
        diag_col = (cx >= q) && (cx < smq);

        hits_next.edge_hit = in_image && (hband || vband);
        hits_next.fill_hit = in_image && fill_en && fill_col && fill_row;
        hits_next.diag_hit = in_image && diag_col &&
                             (in_rng(d1, nh, tm1) || in_rng(d2, nh, tm1));
        hits_next.lim_ok   = lim_ok;
        // disc offsets: columns X and X+S, rows H-Y and H-Y-S
        hits_next.ok_dx    = {in_rng(cxs, nh, h), in_rng(cx, nh, h)};
        hits_next.ok_dy    = {in_rng(cys, nh, h), in_rng(cy, nh, h)};

        dx0_next = mag_of(cx);
        dx1_next = mag_of(cxs);
        dy0_next = mag_of(cy);
        dy1_next = mag_of(cys);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            hits_reg  <= hits_next;
            dx0_reg   <= dx0_next;
            dx1_reg   <= dx1_next;
            dy0_reg   <= dy0_next;
            dy1_reg   <= dy1_next;
            color_reg <= in_color;
        end
    end

    assign out_valid = valid_reg;
    assign hits      = hits_reg;
    assign dx0       = dx0_reg;
    assign dx1       = dx1_reg;
    assign dy0       = dy0_reg;
    assign dy1       = dy1_reg;
    assign out_color = color_reg;

endmodule

`default_nettype wire

[rtl/core/sqd_square.sv]
// ----------------------------------------------------------------------------
// sqd_square
// Stage 3: squares of the corner disc offsets and of the disc radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqd_square
    import sqd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hit_t                hits,
    input  wire mag_t                dx0,
    input  wire mag_t                dx1,
    input  wire mag_t                dy0,
    input  wire mag_t                dy1,
    input  wire color_t              in_color,
    input  wire logic [THICK_W-1:0]  line_thickness,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output hit_t                     out_hits,
    output sq_t                      dx0_sq,
    output sq_t                      dx1_sq,
    output sq_t                      dy0_sq,
    output sq_t                      dy1_sq,
    output sq_t                      rad_sq,
    output color_t                   out_color
);

    logic   valid_reg;
    hit_t   hits_reg;
    sq_t    dx0_sq_reg, dx1_sq_reg, dy0_sq_reg, dy1_sq_reg, rad_sq_reg;
    sq_t    dx0_sq_next, dx1_sq_next, dy0_sq_next, dy1_sq_next, rad_sq_next;
    color_t color_reg;
    mag_t   rad;

    assign rad = line_thickness[THICK_W-1:1];

    always_comb begin
        dx0_sq_next = {{HALF_W{1'b0}}, dx0} * {{HALF_W{1'b0}}, dx0};
        dx1_sq_next = {{HALF_W{1'b0}}, dx1} * {{HALF_W{1'b0}}, dx1};
        dy0_sq_next = {{HALF_W{1'b0}}, dy0} * {{HALF_W{1'b0}}, dy0};
        dy1_sq_next = {{HALF_W{1'b0}}, dy1} * {{HALF_W{1'b0}}, dy1};
        rad_sq_next = {{HALF_W{1'b0}}, rad} * {{HALF_W{1'b0}}, rad};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            hits_reg   <= hits;
            dx0_sq_reg <= dx0_sq_next;
            dx1_sq_reg <= dx1_sq_next;
            dy0_sq_reg <= dy0_sq_next;
            dy1_sq_reg <= dy1_sq_next;
            rad_sq_reg <= rad_sq_next;
            color_reg  <= in_color;
        end
    end

    assign out_valid = valid_reg;
    assign out_hits  = hits_reg;
    assign dx0_sq    = dx0_sq_reg;
    assign dx1_sq    = dx1_sq_reg;
    assign dy0_sq    = dy0_sq_reg;
    assign dy1_sq    = dy1_sq_reg;
    assign rad_sq    = rad_sq_reg;
    assign out_color = color_reg;

endmodule

`default_nettype wire

[rtl/core/sqd_shade.sv]
// ----------------------------------------------------------------------------
// sqd_shade
// Stage 4: corner disc test, layer priority and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqd_shade
    import sqd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hit_t                hits,
    input  wire sq_t                 dx0_sq,
    input  wire sq_t                 dx1_sq,
    input  wire sq_t                 dy0_sq,
    input  wire sq_t                 dy1_sq,
    input  wire sq_t                 rad_sq,
    input  wire color_t              in_color,
    input  wire color_t              line_color,
    input  wire color_t              fill_color,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output color_t                   out_color
);

    logic          valid_reg;
    color_t        color_reg, color_next;
    logic [SQ_W:0] s00, s01, s10, s11, lim;
    logic          disc_hit;

    always_comb begin
        lim = {1'b0, rad_sq};
        s00 = {1'b0, dx0_sq} + {1'b0, dy0_sq};
        s01 = {1'b0, dx0_sq} + {1'b0, dy1_sq};
        s10 = {1'b0, dx1_sq} + {1'b0, dy0_sq};
        s11 = {1'b0, dx1_sq} + {1'b0, dy1_sq};
        disc_hit = hits.lim_ok && (
                   (hits.ok_dx[0] && hits.ok_dy[0] && (s00 <= lim)) ||
                   (hits.ok_dx[0] && hits.ok_dy[1] && (s01 <= lim)) ||
                   (hits.ok_dx[1] && hits.ok_dy[0] && (s10 <= lim)) ||
                   (hits.ok_dx[1] && hits.ok_dy[1] && (s11 <= lim)));

        // later layer wins: outline/discs, then fill, then diagonals
        color_next = in_color;
        if (hits.edge_hit || disc_hit) begin
            color_next = line_color;
        end
        if (hits.fill_hit) begin
            color_next = fill_color;
        end
        if (hits.diag_hit) begin
            color_next = line_color;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            color_reg <= color_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_color = color_reg;

endmodule

`default_nettype wire

[rtl/core/thick_square_with_diagonals_shader.sv]
// ----------------------------------------------------------------------------
// thick_square_with_diagonals_shader
// Per-pixel shader drawing a thick square outline, corner discs, an optional
// inner fill and two diagonal bands over an incoming pixel stream.
// ----------------------------------------------------------------------------
// Pipeline: 4 register stages (sqd_diff, sqd_test, sqd_square, sqd_shade);
// m_tdata comes straight from the sqd_shade register.
// Throughput: one item per cycle while m_tready is high; a stalled output backs
// up without loss: each stage holds one item and moves on when the next has room.
// Reset: synchronous active-low aresetn clears all stage valid bits and loads
// register defaults (thickness 1, image 1x1, everything else 0).
`timescale 1ns / 1ps
`default_nettype none

module thick_square_with_diagonals_shader
    import sqd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // pixel_row, pixel_col, in_red, in_green, in_blue (from bit 0 up)
    input  wire logic [((2*COORD_BITS+24+7)/8)*8-1:0]     s_tdata,
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // out_red, out_green, out_blue (from bit 0 up)
    output logic [COLOR_W-1:0]                            m_tdata,
    input  wire logic                                     psel,
    input  wire logic                                     penable,
    input  wire logic                                     pwrite,
    input  wire logic [APB_ADDR_W-1:0]                    paddr,
    input  wire logic [APB_DATA_W-1:0]                    pwdata,
    output logic [APB_DATA_W-1:0]                         prdata,
    output logic                                          pready
);

    localparam int SW = COORD_BITS + 5;

    logic [COORD_BITS-1:0] x_origin, y_origin, side_length;
    logic [THICK_W-1:0]    line_thickness;
    color_t                line_color;
    logic [FILL_W-1:0]     fill_setting;
    logic [COORD_BITS:0]   image_height, image_width;

    color_t               px_color;
    logic                 v1, r1, v2, r2, v3, r3;
    logic signed [SW-1:0] cx, cy;
    logic                 in_image, lim_ok;
    color_t               c1, c2, c3, c4;
    hit_t                 hits2, hits3;
    mag_t                 dx0, dx1, dy0, dy1;
    sq_t                  dx0_sq, dx1_sq, dy0_sq, dy1_sq, rad_sq;

    assign pready   = 1'b1;
    assign px_color = {s_tdata[2*COORD_BITS +: 8],
                       s_tdata[2*COORD_BITS+8 +: 8],
                       s_tdata[2*COORD_BITS+16 +: 8]};

    sqd_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .x_origin       (x_origin),
        .y_origin       (y_origin),
        .side_length    (side_length),
        .line_thickness (line_thickness),
        .line_color     (line_color),
        .fill_setting   (fill_setting),
        .image_height   (image_height),
        .image_width    (image_width)
    );

    sqd_diff #(.COORD_BITS(COORD_BITS), .SW(SW)) u_diff (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .pixel_row    (s_tdata[COORD_BITS-1:0]),
        .pixel_col    (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_color     (px_color),
        .x_origin     (x_origin),
        .y_origin     (y_origin),
        .image_height (image_height),
        .image_width  (image_width),
        .out_valid    (v1),
        .out_ready    (r1),
        .cx           (cx),
        .cy           (cy),
        .in_image     (in_image),
        .lim_ok       (lim_ok),
        .out_color    (c1)
    );

    sqd_test #(.COORD_BITS(COORD_BITS), .SW(SW)) u_test (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (v1),
        .in_ready       (r1),
        .cx             (cx),
        .cy             (cy),
        .in_image       (in_image),
        .lim_ok         (lim_ok),
        .in_color       (c1),
        .side_length    (side_length),
        .line_thickness (line_thickness),
        .fill_en        (fill_setting[COLOR_W]),
        .out_valid      (v2),
        .out_ready      (r2),
        .hits           (hits2),
        .dx0            (dx0),
        .dx1            (dx1),
        .dy0            (dy0),
        .dy1            (dy1),
        .out_color      (c2)
    );

    sqd_square u_square (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (v2),
        .in_ready       (r2),
        .hits           (hits2),
        .dx0            (dx0),
        .dx1            (dx1),
        .dy0            (dy0),
        .dy1            (dy1),
        .in_color       (c2),
        .line_thickness (line_thickness),
        .out_valid      (v3),
        .out_ready      (r3),
        .out_hits       (hits3),
        .dx0_sq         (dx0_sq),
        .dx1_sq         (dx1_sq),
        .dy0_sq         (dy0_sq),
        .dy1_sq         (dy1_sq),
        .rad_sq         (rad_sq),
        .out_color      (c3)
    );

    sqd_shade u_shade (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v3),
        .in_ready   (r3),
        .hits       (hits3),
        .dx0_sq     (dx0_sq),
        .dx1_sq     (dx1_sq),
        .dy0_sq     (dy0_sq),
        .dy1_sq     (dy1_sq),
        .rad_sq     (rad_sq),
        .in_color   (c3),
        .line_color (line_color),
        .fill_color (fill_setting[COLOR_W-1:0]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_color  (c4)
    );

    assign m_tdata = {c4[7:0], c4[15:8], c4[23:16]};

endmodule

`default_nettype wire

[rtl/core/sqd_check.sv]
// ----------------------------------------------------------------------------
// sqd_check
// Port-level checks for the shader pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqd_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        pready
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_tvalid && s_tready, 4) && $past(aresetn, 4) &&
        $past(aresetn, 3) && $past(aresetn, 2) && $past(aresetn, 1) &&
        $past(m_tready, 3) && $past(m_tready, 2) && $past(m_tready, 1)
        |-> m_tvalid)
        else $error("item did not reach output in four cycles");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind thick_square_with_diagonals_shader sqd_check u_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

`default_nettype wire
